>>> design/mtpp_pkg.sv
// Shared constants, register indexes and types for the median threshold peak picker.
`default_nettype none

package mtpp_pkg;

    localparam int CFG_BITS   = 24;
    localparam int IDX_BITS   = 3;
    localparam int WIN_BITS   = 4;
    localparam int MULT_BITS  = 8;
    localparam int FLOOR_BITS = 24;
    localparam int LB_BITS    = 3;
    localparam int GAP_BITS   = 8;
    localparam int FRAC_SHIFT = 6;
    localparam int CNT_BITS   = 32;

    localparam logic [IDX_BITS-1:0] CFG_WINDOW   = 3'd0;
    localparam logic [IDX_BITS-1:0] CFG_MULT     = 3'd1;
    localparam logic [IDX_BITS-1:0] CFG_FLOOR    = 3'd2;
    localparam logic [IDX_BITS-1:0] CFG_LOOKBACK = 3'd3;
    localparam logic [IDX_BITS-1:0] CFG_MIN_GAP  = 3'd4;

    localparam logic [WIN_BITS-1:0]   RST_WINDOW   = 4'd13;
    localparam logic [MULT_BITS-1:0]  RST_MULT     = 8'd96;
    localparam logic [FLOOR_BITS-1:0] RST_FLOOR    = 24'd41;
    localparam logic [LB_BITS-1:0]    RST_LOOKBACK = 3'd4;
    localparam logic [GAP_BITS-1:0]   RST_MIN_GAP  = 8'd4;

    localparam logic ACT_FRAME = 1'b0;
    localparam logic ACT_SKIP  = 1'b1;

    typedef struct packed {
        logic shift;
        logic step;
    } t_cell_ctl;

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_RANK = 8'b0000_0010,
        S_SEL  = 8'b0000_0100,
        S_MED  = 8'b0000_1000,
        S_MUL  = 8'b0001_0000,
        S_THR  = 8'b0010_0000,
        S_ENV  = 8'b0100_0000,
        S_PICK = 8'b1000_0000
    } t_state;

endpackage

`default_nettype wire

>>> design/median_threshold_peak_picker_top.sv
// Top level of the median threshold peak picker: sequencer, threshold datapath and cell chains.
//
// channel  dir  handshake                  word
// in       in   i_in_valid / o_in_stall    i_action, i_flux, i_emit_enable
// out      out  o_out_valid / i_out_stall  o_envelope, o_onset, o_onset_strength
// cfg      in   i_cfg_we                   i_cfg_index, i_cfg_data
//
// A frame word runs a rank pass over n stored values, n = min(window_frames, FLUX_DEPTH,
// frames seen), one stored flux value moving down the cell chain per cycle, then the
// select, median, multiply, threshold, envelope and pick steps; pick waits for a free
// output slot. A skipped word goes straight to pick. Reset is synchronous and clears the
// sequencer, counters, fill level and lookback; registers return to their defaults.
// o_in_stall is high from acceptance until the result is loaded; a held result does
// not block the next word.
`default_nettype none

module median_threshold_peak_picker_top
    import mtpp_pkg::*;
#(
    parameter int FLUX_DEPTH = 13,
    parameter int ENV_DEPTH  = 8,
    parameter int VALUE_BITS = 24
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic                  i_action,
    input  logic [VALUE_BITS-1:0] i_flux,
    input  logic                  i_emit_enable,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [VALUE_BITS-1:0] o_envelope,
    output logic                  o_onset,
    output logic [VALUE_BITS-1:0] o_onset_strength,
    input  logic                  i_cfg_we,
    input  logic [IDX_BITS-1:0]   i_cfg_index,
    input  logic [CFG_BITS-1:0]   i_cfg_data
);

    localparam int KW  = $clog2(FLUX_DEPTH);
    localparam int NW  = $clog2(FLUX_DEPTH + 1);
    localparam int WCW = (NW > WIN_BITS) ? NW : WIN_BITS;
    localparam int HN  = ENV_DEPTH - 1;
    localparam int EW  = $clog2(ENV_DEPTH);
    localparam int LW  = (EW > LB_BITS) ? EW : LB_BITS;
    localparam int PW  = VALUE_BITS + MULT_BITS;
    localparam int SW  = PW - FRAC_SHIFT;
    localparam logic [VALUE_BITS-1:0] VMAX = '1;

    // configuration
    logic [WIN_BITS-1:0]   r_window;
    logic [MULT_BITS-1:0]  r_mult;
    logic [FLOOR_BITS-1:0] r_floor;
    logic [LB_BITS-1:0]    r_lookback;
    logic [GAP_BITS-1:0]   r_min_gap;

    // control
    t_state              r_state;
    t_state              n_state;
    logic [NW-1:0]       r_fill;
    logic [NW-1:0]       r_n;
    logic [NW-1:0]       r_k;
    logic [CNT_BITS-1:0] r_frame_cnt;
    logic [CNT_BITS-1:0] r_last_onset;
    logic                r_out_valid;

    // datapath
    logic [VALUE_BITS-1:0] r_flux;
    logic                  r_emit;
    logic                  r_skip;
    logic [VALUE_BITS-1:0] r_med_hi;
    logic [VALUE_BITS-1:0] r_med_lo;
    logic [VALUE_BITS-1:0] r_median;
    logic [PW-1:0]         r_prod;
    logic [VALUE_BITS-1:0] r_thr;
    logic [VALUE_BITS-1:0] r_env;
    logic                  r_lb_ok;
    logic                  r_gap_ok;
    logic [VALUE_BITS-1:0] r_out_env;
    logic                  r_out_onset;
    logic [VALUE_BITS-1:0] r_out_strength;

    logic                  w_in_acc;
    logic                  w_frame_acc;
    logic                  w_out_free;
    logic                  w_load_out;
    logic                  w_hist_shift;
    logic                  w_pick;
    logic [NW-1:0]         w_fill_nx;
    logic [WCW-1:0]        w_win_x;
    logic [WCW-1:0]        w_lim;
    logic [WCW-1:0]        w_fill_x;
    logic [WCW-1:0]        w_n_x;
    logic [NW-1:0]         w_n;
    logic [NW-1:0]         w_tgt_hi;
    logic [NW-1:0]         w_tgt_lo;
    logic [VALUE_BITS-1:0] w_sel_hi;
    logic [VALUE_BITS-1:0] w_sel_lo;
    logic [VALUE_BITS:0]   w_mid_sum;
    logic [SW-1:0]         w_shifted;
    logic [VALUE_BITS-1:0] w_sat;
    logic [VALUE_BITS+FLOOR_BITS-1:0] w_floor_wide;
    logic [VALUE_BITS-1:0] w_floor;
    logic [LW-1:0]         w_lb_x;
    logic [LW-1:0]         w_lb;
    t_cell_ctl             w_ctl;

    logic [VALUE_BITS-1:0] w_val   [FLUX_DEPTH];
    logic [VALUE_BITS-1:0] w_probe [FLUX_DEPTH];
    logic [NW-1:0]         w_rank  [FLUX_DEPTH];
    logic [VALUE_BITS-1:0] w_hist  [HN];
    logic [HN-1:0]         w_block;

    assign o_in_stall  = (r_state != S_IDLE);
    assign w_in_acc    = i_in_valid && !o_in_stall;
    assign w_frame_acc = w_in_acc && (i_action == ACT_FRAME);
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign w_load_out  = (r_state == S_PICK) && w_out_free;
    assign w_hist_shift = w_load_out && !r_skip;

    // window length for this frame
    assign w_fill_nx = (r_fill < NW'(FLUX_DEPTH)) ? r_fill + NW'(1) : r_fill;
    assign w_win_x   = WCW'(r_window);
    assign w_lim     = (w_win_x > WCW'(FLUX_DEPTH)) ? WCW'(FLUX_DEPTH) : w_win_x;
    assign w_fill_x  = WCW'(w_fill_nx);
    assign w_n_x     = (w_fill_x < w_lim) ? w_fill_x : w_lim;
    assign w_n       = w_n_x[NW-1:0];

    // flux cell chain, newest value in cell 0
    assign w_ctl.shift = w_frame_acc;
    assign w_ctl.step  = (r_state == S_RANK);

    for (genvar g = 0; g < FLUX_DEPTH; g++) begin : g_flux
        mtpp_flux_cell #(
            .DEPTH      (FLUX_DEPTH),
            .VALUE_BITS (VALUE_BITS),
            .CELL_IDX   (g)
        ) u_flux_cell (
            .i_clk        (i_clk),
            .i_ctl        (w_ctl),
            .i_prev_val   ((g == 0) ? i_flux : w_val[(g == 0) ? 0 : g - 1]),
            .i_next_probe ((g == FLUX_DEPTH - 1) ? '0
                           : w_probe[(g == FLUX_DEPTH - 1) ? g : g + 1]),
            .i_bcast      (w_probe[0]),
            .i_k          (r_k[KW-1:0]),
            .o_val        (w_val[g]),
            .o_probe      (w_probe[g]),
            .o_rank       (w_rank[g])
        );
    end

    // pick the middle ranks among the active cells
    assign w_tgt_hi = r_n >> 1;
    assign w_tgt_lo = w_tgt_hi - NW'(1);

    always_comb begin
        w_sel_hi = '0;
        w_sel_lo = '0;
        for (int i = 0; i < FLUX_DEPTH; i++) begin
            if (NW'(i) < r_n) begin
                if (w_rank[i] == w_tgt_hi) begin
                    w_sel_hi = w_sel_hi | w_val[i];
                end
                if (w_rank[i] == w_tgt_lo) begin
                    w_sel_lo = w_sel_lo | w_val[i];
                end
            end
        end
    end

    assign w_mid_sum = {1'b0, r_med_hi} + {1'b0, r_med_lo};

    // threshold: scale, saturate, floor
    assign w_shifted    = r_prod[PW-1:FRAC_SHIFT];
    assign w_sat        = (w_shifted > SW'(VMAX)) ? VMAX : w_shifted[VALUE_BITS-1:0];
    assign w_floor_wide = {{VALUE_BITS{1'b0}}, r_floor};
    assign w_floor      = w_floor_wide[VALUE_BITS-1:0];

    assign w_lb_x = LW'(r_lookback);
    assign w_lb   = (w_lb_x > LW'(ENV_DEPTH - 1)) ? LW'(ENV_DEPTH - 1) : w_lb_x;

    // envelope lookback chain, most recent earlier envelope in cell 0
    for (genvar g = 0; g < HN; g++) begin : g_env
        mtpp_env_cell #(
            .VALUE_BITS (VALUE_BITS)
        ) u_env_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_shift  (w_hist_shift),
            .i_prev   ((g == 0) ? r_env : w_hist[(g == 0) ? 0 : g - 1]),
            .i_env    (r_env),
            .i_cmp_en (LW'(g) < w_lb),
            .o_hist   (w_hist[g]),
            .o_block  (w_block[g])
        );
    end

    assign w_pick = !r_skip && r_emit && (r_env != '0) && r_lb_ok && r_gap_ok && !(|w_block);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    if (i_action == ACT_SKIP) begin
                        n_state = S_PICK;
                    end else if (w_n == '0) begin
                        n_state = S_SEL;
                    end else begin
                        n_state = S_RANK;
                    end
                end
            end
            S_RANK: begin
                if (r_k + NW'(1) == r_n) begin
                    n_state = S_SEL;
                end
            end
            S_SEL:  n_state = S_MED;
            S_MED:  n_state = S_MUL;
            S_MUL:  n_state = S_THR;
            S_THR:  n_state = S_ENV;
            S_ENV:  n_state = S_PICK;
            S_PICK: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window   <= RST_WINDOW;
            r_mult     <= RST_MULT;
            r_floor    <= RST_FLOOR;
            r_lookback <= RST_LOOKBACK;
            r_min_gap  <= RST_MIN_GAP;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_WINDOW:   r_window   <= i_cfg_data[WIN_BITS-1:0];
                CFG_MULT:     r_mult     <= i_cfg_data[MULT_BITS-1:0];
                CFG_FLOOR:    r_floor    <= i_cfg_data[FLOOR_BITS-1:0];
                CFG_LOOKBACK: r_lookback <= i_cfg_data[LB_BITS-1:0];
                CFG_MIN_GAP:  r_min_gap  <= i_cfg_data[GAP_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_fill       <= '0;
            r_n          <= '0;
            r_k          <= '0;
            r_frame_cnt  <= '0;
            r_last_onset <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_in_acc) begin
                r_k <= '0;
            end else if (r_state == S_RANK) begin
                r_k <= r_k + NW'(1);
            end
            if (w_frame_acc) begin
                r_fill <= w_fill_nx;
                r_n    <= w_n;
            end
            if (w_load_out) begin
                r_frame_cnt <= r_frame_cnt + CNT_BITS'(1);
                if (w_pick) begin
                    r_last_onset <= r_frame_cnt;
                end
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_flux <= i_flux;
            r_emit <= i_emit_enable;
            r_skip <= (i_action == ACT_SKIP);
        end
        if (r_state == S_SEL) begin
            r_med_hi <= w_sel_hi;
            r_med_lo <= w_sel_lo;
        end
        if (r_state == S_MED) begin
            r_median <= r_n[0] ? r_med_hi : w_mid_sum[VALUE_BITS:1];
        end
        if (r_state == S_MUL) begin
            r_prod <= PW'(r_median) * PW'(r_mult);
        end
        if (r_state == S_THR) begin
            r_thr    <= (w_sat < w_floor) ? w_floor : w_sat;
            r_lb_ok  <= (r_frame_cnt >= CNT_BITS'(w_lb));
            r_gap_ok <= ((r_frame_cnt - r_last_onset) >= CNT_BITS'(r_min_gap));
        end
        if (r_state == S_ENV) begin
            r_env <= (r_flux > r_thr) ? (r_flux - r_thr) : '0;
        end
        if (w_load_out) begin
            r_out_env      <= r_skip ? '0 : r_env;
            r_out_onset    <= w_pick;
            r_out_strength <= w_pick ? r_env : '0;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_envelope       = r_out_env;
    assign o_onset          = r_out_onset;
    assign o_onset_strength = r_out_strength;

    a_onset_strength: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_onset) |-> (o_onset_strength == o_envelope) && (o_envelope != '0))
        else $error("onset word with strength not equal to a positive envelope");

    a_quiet_strength: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_onset) |-> (o_onset_strength == '0))
        else $error("strength nonzero without onset");

    a_rank_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RANK) |-> (r_k < r_n))
        else $error("rank pass ran past the window");

    a_frame_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load_out |=> (r_frame_cnt == $past(r_frame_cnt) + CNT_BITS'(1)))
        else $error("frame counter did not advance with the result");

endmodule

`default_nettype wire

>>> design/mtpp_flux_cell.sv
// Flux window cell: holds one flux value, passes a probe value down the chain and counts its rank.
`default_nettype none

module mtpp_flux_cell
    import mtpp_pkg::*;
#(
    parameter int DEPTH      = 13,
    parameter int VALUE_BITS = 24,
    parameter int CELL_IDX   = 0
) (
    input  logic                         i_clk,
    input  t_cell_ctl                    i_ctl,
    input  logic [VALUE_BITS-1:0]        i_prev_val,
    input  logic [VALUE_BITS-1:0]        i_next_probe,
    input  logic [VALUE_BITS-1:0]        i_bcast,
    input  logic [$clog2(DEPTH)-1:0]     i_k,
    output logic [VALUE_BITS-1:0]        o_val,
    output logic [VALUE_BITS-1:0]        o_probe,
    output logic [$clog2(DEPTH+1)-1:0]   o_rank
);

    localparam int KW = $clog2(DEPTH);
    localparam int RW = $clog2(DEPTH + 1);

    logic [VALUE_BITS-1:0] r_val;
    logic [VALUE_BITS-1:0] r_probe;
    logic [RW-1:0]         r_rank;
    logic                  w_below;

    // ties go to the older position so that ranks stay distinct
    assign w_below = (i_bcast < r_val) || ((i_bcast == r_val) && (i_k < KW'(CELL_IDX)));

    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_val   <= i_prev_val;
            r_probe <= i_prev_val;
            r_rank  <= '0;
        end else if (i_ctl.step) begin
            r_probe <= i_next_probe;
            if (w_below) begin
                r_rank <= r_rank + RW'(1);
            end
        end
    end

    assign o_val   = r_val;
    assign o_probe = r_probe;
    assign o_rank  = r_rank;

endmodule

`default_nettype wire

>>> design/mtpp_env_cell.sv
// Envelope lookback cell: holds one earlier envelope and flags when it blocks the candidate.
`default_nettype none

module mtpp_env_cell
    import mtpp_pkg::*;
#(
    parameter int VALUE_BITS = 24
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_shift,
    input  logic [VALUE_BITS-1:0] i_prev,
    input  logic [VALUE_BITS-1:0] i_env,
    input  logic                  i_cmp_en,
    output logic [VALUE_BITS-1:0] o_hist,
    output logic                  o_block
);

    logic [VALUE_BITS-1:0] r_hist;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist <= '0;
        end else if (i_shift) begin
            r_hist <= i_prev;
        end
    end

    assign o_hist  = r_hist;
    assign o_block = i_cmp_en && (r_hist >= i_env);

endmodule

`default_nettype wire
